// ===== rtl/topic_subscription_matcher_assert.svh =====
// assertion macros used by the port level checker file
`ifndef TOPIC_SUBSCRIPTION_MATCHER_ASSERT_SVH
`define TOPIC_SUBSCRIPTION_MATCHER_ASSERT_SVH

// condition implies consequence in the same cycle
`define TSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define TSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tsm_pkg.sv =====
// shared constants, types and command codes of the subscription matcher
package tsm_pkg;

  localparam int MAX_SUBS    = 48;
  localparam int TOPIC_BYTES = 48;
  localparam int CNT_W       = $clog2(MAX_SUBS + 1);
  localparam int SLOT_W      = (MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1;
  localparam int LEN_W       = $clog2(TOPIC_BYTES);
  localparam int POS_W       = $clog2(TOPIC_BYTES + 1);
  localparam int TEXT_DEPTH  = MAX_SUBS * TOPIC_BYTES;
  localparam int TEXT_AW     = $clog2(TEXT_DEPTH);

  localparam logic [7:0] STAR_CHAR = 8'h2A;

  typedef enum logic [1:0] {
    ACT_SUB   = 2'd0,
    ACT_PUB   = 2'd1,
    ACT_UNSUB = 2'd2,
    ACT_NONE  = 2'd3
  } act_e;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic               prefix;
    logic [31:0]        owner;
    logic signed [31:0] rank;
  } meta_t;

  typedef struct packed {
    logic signed [31:0] rank;
    logic [31:0]        owner;
  } sort_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SUB,
    ST_PM_START, ST_PM_META, ST_PM_LOAD, ST_PM_CMP, ST_PM_DEC,
    ST_SA_CHECK, ST_SA_LOAD, ST_SB, ST_SA_END,
    ST_NOMATCH, ST_EM_RD, ST_EM_OUT,
    ST_UN_START, ST_UN_META, ST_UN_LOAD, ST_UN_MWR, ST_UN_CP, ST_UN_NEXT, ST_UN_END
  } state_e;

  typedef enum logic [4:0] {
    OP_NOP, OP_ACCEPT, OP_SUB,
    OP_PM_START, OP_META_RD, OP_PM_LOAD, OP_CMP, OP_MATCH_DEC,
    OP_SA_RD, OP_SA_LOAD, OP_SB, OP_SA_END,
    OP_NOMATCH, OP_EM_RD, OP_EM_OUT,
    OP_UN_START, OP_UN_LOAD, OP_UN_MWR, OP_UN_CP, OP_UN_NEXT, OP_UN_END
  } cmd_e;

  typedef struct packed {
    logic e_done;
    logic k_done;
    logic a_done;
    logic b_done;
    logic n_zero;
    logic emit_last;
    logic id_hit;
    logic same_pos;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/tsm_ram.sv =====
// generic single write, single read memory with registered read data
module tsm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tsm_ctrl.sv =====
// controller state machine sequencing subscribe, match, sort, emit and compaction
module tsm_ctrl import tsm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] action_i,
  input  logic       topic_last_i,
  input  sts_t       sts_i,
  output logic       in_ready_o,
  output cmd_e       cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (action_i == ACT_UNSUB) begin
            state_d = ST_UN_START;
          end else if (action_i == ACT_NONE) begin
            state_d = ST_IDLE;
          end else if (topic_last_i) begin
            state_d = (action_i == ACT_SUB) ? ST_SUB : ST_PM_START;
          end
        end
      end
      ST_SUB:      if (sts_i.out_free) state_d = ST_IDLE;
      ST_PM_START: state_d = ST_PM_META;
      ST_PM_META:  state_d = sts_i.e_done ? ST_SA_CHECK : ST_PM_LOAD;
      ST_PM_LOAD:  state_d = ST_PM_CMP;
      ST_PM_CMP:   if (sts_i.k_done) state_d = ST_PM_DEC;
      ST_PM_DEC:   state_d = ST_PM_META;
      ST_SA_CHECK: begin
        if (sts_i.a_done) begin
          state_d = sts_i.n_zero ? ST_NOMATCH : ST_EM_RD;
        end else begin
          state_d = ST_SA_LOAD;
        end
      end
      ST_SA_LOAD:  state_d = ST_SB;
      ST_SB:       if (sts_i.b_done) state_d = ST_SA_END;
      ST_SA_END:   state_d = ST_SA_CHECK;
      ST_NOMATCH:  if (sts_i.out_free) state_d = ST_IDLE;
      ST_EM_RD:    state_d = ST_EM_OUT;
      ST_EM_OUT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.emit_last ? ST_IDLE : ST_EM_RD;
        end
      end
      ST_UN_START: state_d = ST_UN_META;
      ST_UN_META:  state_d = sts_i.e_done ? ST_UN_END : ST_UN_LOAD;
      ST_UN_LOAD:  state_d = (sts_i.id_hit || sts_i.same_pos) ? ST_UN_META : ST_UN_MWR;
      ST_UN_MWR:   state_d = ST_UN_CP;
      ST_UN_CP:    if (sts_i.k_done) state_d = ST_UN_NEXT;
      ST_UN_NEXT:  state_d = ST_UN_META;
      ST_UN_END:   if (sts_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd_o      = OP_NOP;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o      = in_valid_i ? OP_ACCEPT : OP_NOP;
      end
      ST_SUB:      cmd_o = sts_i.out_free ? OP_SUB : OP_NOP;
      ST_PM_START: cmd_o = OP_PM_START;
      ST_PM_META:  cmd_o = sts_i.e_done ? OP_NOP : OP_META_RD;
      ST_PM_LOAD:  cmd_o = OP_PM_LOAD;
      ST_PM_CMP:   cmd_o = OP_CMP;
      ST_PM_DEC:   cmd_o = OP_MATCH_DEC;
      ST_SA_CHECK: cmd_o = sts_i.a_done ? OP_NOP : OP_SA_RD;
      ST_SA_LOAD:  cmd_o = OP_SA_LOAD;
      ST_SB:       cmd_o = OP_SB;
      ST_SA_END:   cmd_o = OP_SA_END;
      ST_NOMATCH:  cmd_o = sts_i.out_free ? OP_NOMATCH : OP_NOP;
      ST_EM_RD:    cmd_o = OP_EM_RD;
      ST_EM_OUT:   cmd_o = sts_i.out_free ? OP_EM_OUT : OP_NOP;
      ST_UN_START: cmd_o = OP_UN_START;
      ST_UN_META:  cmd_o = sts_i.e_done ? OP_NOP : OP_META_RD;
      ST_UN_LOAD:  cmd_o = OP_UN_LOAD;
      ST_UN_MWR:   cmd_o = OP_UN_MWR;
      ST_UN_CP:    cmd_o = OP_UN_CP;
      ST_UN_NEXT:  cmd_o = OP_UN_NEXT;
      ST_UN_END:   cmd_o = sts_i.out_free ? OP_UN_END : OP_NOP;
      default:     cmd_o = OP_NOP;
    endcase
  end

endmodule

// ===== rtl/tsm_datapath.sv =====
// datapath: topic buffers, subscription tables, sort memory and result register
module tsm_datapath import tsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_e        cmd_i,
  output sts_t        sts_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  topic_char_i,
  input  logic [31:0] subscriber_id_i,
  input  logic [31:0] priority_req_i,
  input  logic [5:0]  result_limit_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic        status_o,
  output logic [5:0]  slot_index_o,
  output logic [31:0] matched_id_o,
  output logic        match_valid_o,
  output logic        last_result_o,
  output logic [5:0]  removed_count_o,
  output logic [5:0]  subscriber_total_o
);

  function automatic logic [TEXT_AW-1:0] text_addr(input logic [SLOT_W-1:0] row,
                                                    input logic [LEN_W-1:0]  col);
    return TEXT_AW'(row) * TEXT_AW'(TOPIC_BYTES) + TEXT_AW'(col);
  endfunction

  // control registers
  logic [POS_W-1:0] cp_q, cp_d;
  logic             ended_q, ended_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] e_q, e_d, w_q, w_d, mcnt_q, mcnt_d;
  logic [CNT_W-1:0] a_q, a_d, b_q, b_d, i_q, i_d;
  logic [LEN_W-1:0] k_q, k_d;
  logic             pv_q, pv_d;
  logic             out_valid_q, out_valid_d;
  logic [63:0]      events_q, events_d;

  // payload registers
  logic [7:0]       tail_q, tail_d;
  logic [31:0]      uid_q, uid_d, prio_q, prio_d;
  logic [5:0]       limit_q, limit_d;
  meta_t            cur_q, cur_d;
  logic [LEN_W-1:0] n_q, n_d;
  logic             len_ok_q, len_ok_d, mism_q, mism_d;
  sort_t            acc_q, acc_d;
  logic             status_q, mv_q, last_q;
  logic [5:0]       slot_q, removed_q, total_q;
  logic [31:0]      id_q;

  // result load
  logic             ld, ld_status, ld_mv, ld_last;
  logic [5:0]       ld_slot, ld_removed, ld_total;
  logic [31:0]      ld_id;

  // memory ports
  logic               text_we, text_re, pend_we, pend_re;
  logic [TEXT_AW-1:0] text_waddr, text_raddr;
  logic [LEN_W-1:0]   pend_waddr, pend_raddr;
  logic [7:0]         text_wdata;
  logic [7:0]         text_rdata, pend_rdata;
  logic               meta_we, meta_re;
  logic [SLOT_W-1:0]  meta_waddr, meta_raddr;
  meta_t              meta_wdata, meta_rdata;
  logic               sort_we, sort_re;
  logic [SLOT_W-1:0]  sort_waddr, sort_raddr;
  sort_t              sort_wdata, sort_rdata;

  logic             full;
  logic [CNT_W-1:0] n_emit;
  logic [CNT_W:0]   i_inc;
  logic [LEN_W-1:0] pl;
  logic [LEN_W-1:0] stored_len;

  assign full   = (count_q == CNT_W'(MAX_SUBS));
  assign n_emit = (int'(limit_q) < int'(mcnt_q)) ? CNT_W'(limit_q) : mcnt_q;
  assign i_inc  = {1'b0, i_q} + 1'b1;
  assign pl     = (meta_rdata.len == '0) ? '0 : meta_rdata.len - 1'b1;
  assign stored_len = (int'(cp_q) < TOPIC_BYTES - 1) ? cp_q[LEN_W-1:0]
                                                      : LEN_W'(TOPIC_BYTES - 1);

  // status to the controller
  always_comb begin
    sts_o.e_done    = (e_q == count_q);
    sts_o.k_done    = (k_q == n_q);
    sts_o.a_done    = (({1'b0, a_q} + 1'b1) >= {1'b0, mcnt_q});
    sts_o.b_done    = (b_q == mcnt_q);
    sts_o.n_zero    = (n_emit == '0);
    sts_o.emit_last = (i_inc == {1'b0, n_emit});
    sts_o.id_hit    = (meta_rdata.owner == uid_q);
    sts_o.same_pos  = (w_q == e_q);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // command decode
  always_comb begin
    cp_d = cp_q; ended_d = ended_q; count_d = count_q;
    e_d = e_q; w_d = w_q; mcnt_d = mcnt_q; a_d = a_q; b_d = b_q; i_d = i_q;
    k_d = k_q; pv_d = pv_q; events_d = events_q;
    tail_d = tail_q; uid_d = uid_q; prio_d = prio_q; limit_d = limit_q;
    cur_d = cur_q; n_d = n_q; len_ok_d = len_ok_q; mism_d = mism_q; acc_d = acc_q;

    ld = 1'b0; ld_status = 1'b0; ld_mv = 1'b0; ld_last = 1'b1;
    ld_slot = '0; ld_removed = '0; ld_total = 6'(count_q); ld_id = '0;

    text_we = 1'b0; text_re = 1'b0; pend_we = 1'b0; pend_re = 1'b0;
    text_waddr = '0; text_raddr = '0; pend_waddr = '0; pend_raddr = '0;
    text_wdata = topic_char_i;
    meta_we = 1'b0; meta_re = 1'b0; meta_waddr = '0; meta_raddr = '0;
    meta_wdata = cur_q;
    sort_we = 1'b0; sort_re = 1'b0; sort_waddr = '0; sort_raddr = '0;
    sort_wdata = acc_q;

    case (cmd_i)
      OP_ACCEPT: begin
        uid_d   = subscriber_id_i;
        prio_d  = priority_req_i;
        limit_d = result_limit_i;
        if ((action_i == ACT_SUB || action_i == ACT_PUB) && !ended_q) begin
          if (topic_char_i == '0) begin
            ended_d = 1'b1;
          end else begin
            if (int'(cp_q) < TOPIC_BYTES - 1) begin
              pend_we    = 1'b1;
              pend_waddr = cp_q[LEN_W-1:0];
              text_we    = !full;
              text_waddr = text_addr(count_q[SLOT_W-1:0], cp_q[LEN_W-1:0]);
            end
            if (int'(cp_q) < TOPIC_BYTES) begin
              cp_d = cp_q + 1'b1;
            end
            tail_d = topic_char_i;
          end
        end
      end
      OP_SUB: begin
        ld        = 1'b1;
        ld_status = full;
        if (!full) begin
          meta_we           = 1'b1;
          meta_waddr        = count_q[SLOT_W-1:0];
          meta_wdata.len    = stored_len;
          meta_wdata.prefix = (cp_q != '0) && (tail_q == STAR_CHAR);
          meta_wdata.owner  = uid_q;
          meta_wdata.rank   = prio_q;
          count_d           = count_q + 1'b1;
          ld_slot           = 6'(count_q);
          ld_total          = 6'(count_q + 1'b1);
        end
        cp_d = '0; ended_d = 1'b0;
      end
      OP_PM_START: begin
        e_d = '0; mcnt_d = '0; a_d = '0; i_d = '0;
        events_d = events_q + 64'd1;
      end
      OP_META_RD: begin
        meta_re    = 1'b1;
        meta_raddr = e_q[SLOT_W-1:0];
      end
      OP_PM_LOAD: begin
        cur_d  = meta_rdata;
        k_d    = '0;
        pv_d   = 1'b0;
        mism_d = 1'b0;
        if (meta_rdata.prefix) begin
          len_ok_d = (cp_q >= POS_W'(pl));
          n_d      = pl;
        end else begin
          len_ok_d = (cp_q == POS_W'(meta_rdata.len));
          n_d      = meta_rdata.len;
        end
      end
      OP_CMP: begin
        if (pv_q && (text_rdata != pend_rdata)) begin
          mism_d = 1'b1;
        end
        if (k_q < n_q) begin
          text_re    = 1'b1;
          text_raddr = text_addr(e_q[SLOT_W-1:0], k_q);
          pend_re    = 1'b1;
          pend_raddr = k_q;
          k_d        = k_q + 1'b1;
          pv_d       = 1'b1;
        end else begin
          pv_d = 1'b0;
        end
      end
      OP_MATCH_DEC: begin
        if (len_ok_q && !mism_q) begin
          sort_we          = 1'b1;
          sort_waddr       = mcnt_q[SLOT_W-1:0];
          sort_wdata.rank  = cur_q.rank;
          sort_wdata.owner = cur_q.owner;
          mcnt_d           = mcnt_q + 1'b1;
        end
        e_d = e_q + 1'b1;
      end
      OP_SA_RD: begin
        sort_re    = 1'b1;
        sort_raddr = a_q[SLOT_W-1:0];
      end
      OP_SA_LOAD: begin
        acc_d = sort_rdata;
        b_d   = a_q + 1'b1;
        pv_d  = 1'b0;
      end
      OP_SB: begin
        // swap a strictly higher rank into the held position
        if (pv_q && ($signed(sort_rdata.rank) > $signed(acc_q.rank))) begin
          sort_we    = 1'b1;
          sort_waddr = SLOT_W'(b_q - 1'b1);
          sort_wdata = acc_q;
          acc_d      = sort_rdata;
        end
        if (b_q < mcnt_q) begin
          sort_re    = 1'b1;
          sort_raddr = b_q[SLOT_W-1:0];
          b_d        = b_q + 1'b1;
          pv_d       = 1'b1;
        end else begin
          pv_d = 1'b0;
        end
      end
      OP_SA_END: begin
        sort_we    = 1'b1;
        sort_waddr = a_q[SLOT_W-1:0];
        a_d        = a_q + 1'b1;
      end
      OP_NOMATCH: begin
        ld = 1'b1;
        cp_d = '0; ended_d = 1'b0;
      end
      OP_EM_RD: begin
        sort_re    = 1'b1;
        sort_raddr = i_q[SLOT_W-1:0];
      end
      OP_EM_OUT: begin
        ld      = 1'b1;
        ld_id   = sort_rdata.owner;
        ld_mv   = 1'b1;
        ld_last = sts_o.emit_last;
        i_d     = i_q + 1'b1;
        if (sts_o.emit_last) begin
          cp_d = '0; ended_d = 1'b0;
        end
      end
      OP_UN_START: begin
        e_d = '0; w_d = '0;
      end
      OP_UN_LOAD: begin
        cur_d = meta_rdata;
        n_d   = meta_rdata.len;
        k_d   = '0;
        pv_d  = 1'b0;
        if (sts_o.id_hit) begin
          e_d = e_q + 1'b1;
        end else if (sts_o.same_pos) begin
          e_d = e_q + 1'b1;
          w_d = w_q + 1'b1;
        end
      end
      OP_UN_MWR: begin
        meta_we    = 1'b1;
        meta_waddr = w_q[SLOT_W-1:0];
      end
      OP_UN_CP: begin
        // row copy: read one byte ahead, write the byte read last cycle
        if (pv_q) begin
          text_we    = 1'b1;
          text_waddr = text_addr(w_q[SLOT_W-1:0], k_q - 1'b1);
          text_wdata = text_rdata;
        end
        if (k_q < n_q) begin
          text_re    = 1'b1;
          text_raddr = text_addr(e_q[SLOT_W-1:0], k_q);
          k_d        = k_q + 1'b1;
          pv_d       = 1'b1;
        end else begin
          pv_d = 1'b0;
        end
      end
      OP_UN_NEXT: begin
        e_d = e_q + 1'b1;
        w_d = w_q + 1'b1;
      end
      OP_UN_END: begin
        ld         = 1'b1;
        ld_removed = 6'(count_q - w_q);
        ld_total   = 6'(w_q);
        count_d    = w_q;
        cp_d = '0; ended_d = 1'b0;
      end
      default: begin
        ld = 1'b0;
      end
    endcase

    if (ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_q <= '0; ended_q <= 1'b0; count_q <= '0;
      e_q <= '0; w_q <= '0; mcnt_q <= '0; a_q <= '0; b_q <= '0; i_q <= '0;
      k_q <= '0; pv_q <= 1'b0; out_valid_q <= 1'b0; events_q <= '0;
    end else begin
      cp_q <= cp_d; ended_q <= ended_d; count_q <= count_d;
      e_q <= e_d; w_q <= w_d; mcnt_q <= mcnt_d; a_q <= a_d; b_q <= b_d; i_q <= i_d;
      k_q <= k_d; pv_q <= pv_d; out_valid_q <= out_valid_d; events_q <= events_d;
    end
  end

  // payload and result register
  always_ff @(posedge clk_i) begin
    tail_q <= tail_d; uid_q <= uid_d; prio_q <= prio_d; limit_q <= limit_d;
    cur_q <= cur_d; n_q <= n_d; len_ok_q <= len_ok_d; mism_q <= mism_d; acc_q <= acc_d;
    if (ld) begin
      status_q  <= ld_status;
      slot_q    <= ld_slot;
      id_q      <= ld_id;
      mv_q      <= ld_mv;
      last_q    <= ld_last;
      removed_q <= ld_removed;
      total_q   <= ld_total;
    end
  end

  // stored topic text, one row per slot
  tsm_ram #(.Width(8), .Depth(TEXT_DEPTH)) u_text_ram (
    .clk_i, .we_i(text_we), .waddr_i(text_waddr), .wdata_i(text_wdata),
    .re_i(text_re), .raddr_i(text_raddr), .rdata_o(text_rdata)
  );

  // topic being collected
  tsm_ram #(.Width(8), .Depth(TOPIC_BYTES)) u_pend_ram (
    .clk_i, .we_i(pend_we), .waddr_i(pend_waddr), .wdata_i(topic_char_i),
    .re_i(pend_re), .raddr_i(pend_raddr), .rdata_o(pend_rdata)
  );

  // per slot length, wildcard flag, owner and rank
  tsm_ram #(.Width($bits(meta_t)), .Depth(MAX_SUBS)) u_meta_ram (
    .clk_i, .we_i(meta_we), .waddr_i(meta_waddr), .wdata_i(meta_wdata),
    .re_i(meta_re), .raddr_i(meta_raddr), .rdata_o(meta_rdata)
  );

  // matches in sort order
  tsm_ram #(.Width($bits(sort_t)), .Depth(MAX_SUBS)) u_sort_ram (
    .clk_i, .we_i(sort_we), .waddr_i(sort_waddr), .wdata_i(sort_wdata),
    .re_i(sort_re), .raddr_i(sort_raddr), .rdata_o(sort_rdata)
  );

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign slot_index_o       = slot_q;
  assign matched_id_o       = id_q;
  assign match_valid_o      = mv_q;
  assign last_result_o      = last_q;
  assign removed_count_o    = removed_q;
  assign subscriber_total_o = total_q;

endmodule

// ===== rtl/topic_subscription_matcher.sv =====
// topic character that is not the last of a topic: taken while idle, next one right after
// subscribe: result loaded once the result register is free; publish: every stored entry is
//   compared, the matches are exchange sorted by rank, then one id per result is emitted
// unsubscribe: checks every stored entry, copies meta and text row of each entry that moves
// one transaction at a time; result register lets the next item in while a result waits
// reset clears counters and state only; table memories need no clearing pass
module topic_subscription_matcher import tsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  topic_char_i,
  input  logic        topic_last_i,
  input  logic [31:0] subscriber_id_i,
  input  logic [31:0] priority_req_i,
  input  logic [5:0]  result_limit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [5:0]  slot_index_o,
  output logic [31:0] matched_id_o,
  output logic        match_valid_o,
  output logic        last_result_o,
  output logic [5:0]  removed_count_o,
  output logic [5:0]  subscriber_total_o
);

  cmd_e cmd;
  sts_t sts;

  // sequencing
  tsm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .action_i, .topic_last_i,
    .sts_i(sts), .in_ready_o, .cmd_o(cmd)
  );

  // storage and result path
  tsm_datapath u_datapath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .action_i, .topic_char_i, .subscriber_id_i, .priority_req_i, .result_limit_i,
    .out_ready_i, .out_valid_o, .status_o, .slot_index_o, .matched_id_o,
    .match_valid_o, .last_result_o, .removed_count_o, .subscriber_total_o
  );

endmodule

// ===== rtl/tsm_checker.sv =====
// port level checks for the subscription matcher, bound to the top level
`include "topic_subscription_matcher_assert.svh"

module tsm_checker import tsm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  action_i,
  input logic [7:0]  topic_char_i,
  input logic        topic_last_i,
  input logic [31:0] subscriber_id_i,
  input logic [31:0] priority_req_i,
  input logic [5:0]  result_limit_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        status_o,
  input logic [5:0]  slot_index_o,
  input logic [31:0] matched_id_o,
  input logic        match_valid_o,
  input logic        last_result_o,
  input logic [5:0]  removed_count_o,
  input logic [5:0]  subscriber_total_o
);

  // stalled result stays offered
  `TSM_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")

  // full table result carries no slot and a full count
  `TSM_ASSERT_IMP(a_full_result, out_valid_o && status_o, slot_index_o == '0 && !match_valid_o && subscriber_total_o == 6'(MAX_SUBS), "bad full result")

  // a match result is neither a subscribe nor an unsubscribe result
  `TSM_ASSERT_IMP(a_match_clean, out_valid_o && match_valid_o, !status_o && removed_count_o == '0 && slot_index_o == '0, "mixed result")

  // compaction keeps input closed after the unsubscribe transaction
  `TSM_ASSERT_NXT(a_unsub_busy, in_valid_i && in_ready_o && action_i == ACT_UNSUB, !in_ready_o, "input open during compaction")

endmodule

bind topic_subscription_matcher tsm_checker u_tsm_checker (.*);

// ===== test/tsm_checker.sv =====
// transaction checker with a behavioral predictor of the subscription matcher
module tsm_tb_checker import tsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic [7:0]  topic_char_i,
  input  logic        topic_last_i,
  input  logic [31:0] subscriber_id_i,
  input  logic [31:0] priority_req_i,
  input  logic [5:0]  result_limit_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        status_i,
  input  logic [5:0]  slot_index_i,
  input  logic [31:0] matched_id_i,
  input  logic        match_valid_i,
  input  logic        last_result_i,
  input  logic [5:0]  removed_count_i,
  input  logic [5:0]  subscriber_total_i,
  output int          errors_o,
  output int          outstanding_o
);

  typedef struct packed {
    logic        status;
    logic [5:0]  slot;
    logic [31:0] id;
    logic        valid;
    logic        last;
    logic [5:0]  removed;
    logic [5:0]  total;
  } reply_t;

  reply_t     replies_q[$];

  // predicted table contents
  logic [7:0]         tbl_text[MAX_SUBS][TOPIC_BYTES];
  int                 tbl_len[MAX_SUBS];
  logic               tbl_wild[MAX_SUBS];
  logic [31:0]        tbl_owner[MAX_SUBS];
  logic signed [31:0] tbl_rank[MAX_SUBS];
  int                 n_entries;

  // topic being collected
  logic [7:0] buf_text[TOPIC_BYTES];
  int         buf_pos;
  logic       buf_ended;
  logic [7:0] buf_tail;

  assign outstanding_o = replies_q.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  task automatic push_reply(input logic st, input int slot, input logic [31:0] id,
                            input logic v, input logic last, input int removed);
    reply_t r;
    r.status = st; r.slot = slot[5:0]; r.id = id; r.valid = v; r.last = last;
    r.removed = removed[5:0]; r.total = n_entries[5:0];
    replies_q.push_back(r);
  endtask

  function automatic logic topic_hits(input int e);
    int  cmp_len;
    logic ok;
    ok = 1'b1;
    if (tbl_wild[e]) begin
      cmp_len = (tbl_len[e] > 0) ? tbl_len[e] - 1 : 0;
      if (buf_pos < cmp_len) return 1'b0;
    end else begin
      cmp_len = tbl_len[e];
      if (buf_pos != cmp_len) return 1'b0;
    end
    for (int k = 0; k < cmp_len; k++)
      if (tbl_text[e][k] != buf_text[k]) ok = 1'b0;
    return ok;
  endfunction

  task automatic predict_subscribe(input logic [31:0] id, input logic [31:0] prio);
    int slot;
    int keep;
    if (n_entries >= MAX_SUBS) begin
      push_reply(1'b1, 0, 0, 1'b0, 1'b1, 0);
      return;
    end
    slot = n_entries;
    keep = (buf_pos < TOPIC_BYTES - 1) ? buf_pos : TOPIC_BYTES - 1;
    for (int k = 0; k < TOPIC_BYTES; k++)
      tbl_text[slot][k] = (k < keep) ? buf_text[k] : 8'h00;
    tbl_len[slot]   = keep;
    tbl_wild[slot]  = (buf_pos > 0) && (buf_tail == STAR_CHAR);
    tbl_owner[slot] = id;
    tbl_rank[slot]  = prio;
    n_entries++;
    push_reply(1'b0, slot, 0, 1'b0, 1'b1, 0);
  endtask

  task automatic predict_publish(input int limit);
    int order[MAX_SUBS];
    int hits;
    int n;
    int t;
    hits = 0;
    for (int e = 0; e < n_entries; e++)
      if (topic_hits(e)) begin
        order[hits] = e;
        hits++;
      end
    // exchange sort, unstable among equal ranks
    for (int a = 0; a < hits; a++)
      for (int b = a + 1; b < hits; b++)
        if (tbl_rank[order[b]] > tbl_rank[order[a]]) begin
          t = order[a]; order[a] = order[b]; order[b] = t;
        end
    n = (hits < limit) ? hits : limit;
    if (n == 0) push_reply(1'b0, 0, 0, 1'b0, 1'b1, 0);
    for (int a = 0; a < n; a++)
      push_reply(1'b0, 0, tbl_owner[order[a]], 1'b1, a == n - 1, 0);
  endtask

  task automatic predict_unsubscribe(input logic [31:0] id);
    int w;
    int removed;
    w = 0;
    for (int r = 0; r < n_entries; r++) begin
      if (tbl_owner[r] == id) continue;
      tbl_text[w] = tbl_text[r];
      tbl_len[w] = tbl_len[r];
      tbl_wild[w] = tbl_wild[r];
      tbl_owner[w] = tbl_owner[r];
      tbl_rank[w] = tbl_rank[r];
      w++;
    end
    removed = n_entries - w;
    n_entries = w;
    buf_pos = 0; buf_ended = 1'b0; buf_tail = 8'h00;
    push_reply(1'b0, 0, 0, 1'b0, 1'b1, removed);
  endtask

  task automatic predict_item();
    act_e act;
    act = act_e'(action_i);
    if (act == ACT_UNSUB) begin
      predict_unsubscribe(subscriber_id_i);
      return;
    end
    if (act == ACT_NONE) return;
    // collect the byte; a zero byte ends the text
    if (!buf_ended) begin
      if (topic_char_i == 8'h00) begin
        buf_ended = 1'b1;
      end else begin
        if (buf_pos < TOPIC_BYTES - 1) buf_text[buf_pos] = topic_char_i;
        if (buf_pos < TOPIC_BYTES) buf_pos++;
        buf_tail = topic_char_i;
      end
    end
    if (!topic_last_i) return;
    if (act == ACT_SUB) predict_subscribe(subscriber_id_i, priority_req_i);
    else predict_publish(result_limit_i);
    buf_pos = 0; buf_ended = 1'b0; buf_tail = 8'h00;
  endtask

  initial begin
    errors_o = 0;
    n_entries = 0;
    buf_pos = 0;
    buf_ended = 1'b0;
    buf_tail = 8'h00;
    for (int k = 0; k < TOPIC_BYTES; k++) buf_text[k] = 8'h00;
  end

  // watch both channels at every edge
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (replies_q.size() == 0) begin
          report("unexpected result", matched_id_i, 0);
        end else begin
          want = replies_q.pop_front();
          if (status_i !== want.status) report("status", status_i, want.status);
          if (slot_index_i !== want.slot) report("slot_index", slot_index_i, want.slot);
          if (matched_id_i !== want.id) report("matched_id", matched_id_i, want.id);
          if (match_valid_i !== want.valid) report("match_valid", match_valid_i, want.valid);
          if (last_result_i !== want.last) report("last_result", last_result_i, want.last);
          if (removed_count_i !== want.removed)
            report("removed_count", removed_count_i, want.removed);
          if (subscriber_total_i !== want.total)
            report("subscriber_total", subscriber_total_i, want.total);
        end
      end
      if (in_valid_i && in_ready_i) predict_item();
    end
  end

endmodule

// ===== test/tb_topic_subscription_matcher.sv =====
// testbench top: stimulus, handshake idling and final verdict for the matcher
module tb_topic_subscription_matcher import tsm_pkg::*;;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic [7:0]  topic_char_i;
  logic        topic_last_i;
  logic [31:0] subscriber_id_i;
  logic [31:0] priority_req_i;
  logic [5:0]  result_limit_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        status_o;
  logic [5:0]  slot_index_o;
  logic [31:0] matched_id_o;
  logic        match_valid_o;
  logic        last_result_o;
  logic [5:0]  removed_count_o;
  logic [5:0]  subscriber_total_o;
  int          mismatches;
  int          outstanding;

  int          send_idle_pct;
  int          recv_idle_pct;
  logic [31:0] id_pool[6];

  topic_subscription_matcher uut (.*);

  tsm_tb_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .action_i, .topic_char_i,
    .topic_last_i, .subscriber_id_i, .priority_req_i, .result_limit_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .slot_index_i(slot_index_o), .matched_id_i(matched_id_o),
    .match_valid_i(match_valid_o), .last_result_i(last_result_o),
    .removed_count_i(removed_count_o), .subscriber_total_i(subscriber_total_o),
    .errors_o(mismatches), .outstanding_o(outstanding)
  );

  // clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one transaction on the input channel
  task automatic send_item(input act_e act, input logic [7:0] ch, input logic last,
                           input logic [31:0] id, input logic [31:0] prio,
                           input logic [5:0] lim);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    topic_char_i    <= ch;
    topic_last_i    <= last;
    subscriber_id_i <= id;
    priority_req_i  <= prio;
    result_limit_i  <= lim;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // whole topic, one byte per transaction; empty topic is a lone zero byte
  task automatic send_topic(input act_e act, input logic [7:0] txt[$], input logic [31:0] id,
                            input logic [31:0] prio, input logic [5:0] lim);
    if (txt.size() == 0) begin
      send_item(act, 8'h00, 1'b1, id, prio, lim);
    end else begin
      foreach (txt[k]) send_item(act, txt[k], k == txt.size() - 1, id, prio, lim);
    end
  endtask

  function automatic void make_topic(output logic [7:0] txt[$]);
    logic [7:0] alpha[4] = '{8'h61, 8'h62, STAR_CHAR, 8'h63};
    int len;
    int kind;
    txt = {};
    kind = $urandom_range(99);
    if (kind < 4) len = $urandom_range(8, 5);
    else len = $urandom_range(4);
    for (int k = 0; k < len; k++) begin
      if (kind >= 4 && kind < 12) txt.push_back(8'($urandom_range(255, 1)));
      else txt.push_back(alpha[$urandom_range(3)]);
    end
  endfunction

  function automatic logic [31:0] pick_id();
    if ($urandom_range(9) == 0) return $urandom();
    return id_pool[$urandom_range(5)];
  endfunction

  function automatic logic [31:0] pick_rank();
    if ($urandom_range(4) == 0) return $urandom();
    return $urandom_range(6) - 3;
  endfunction

  function automatic logic [5:0] pick_limit();
    if ($urandom_range(3) == 0) return 6'($urandom_range(48));
    return 6'($urandom_range(6));
  endfunction

  // directed opening: extremes, wildcards, special topics
  task automatic run_directed();
    logic [7:0] t[$];
    t = {};
    send_topic(ACT_PUB, t, 0, 0, 6'd48);
    send_topic(ACT_SUB, t, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    t = {STAR_CHAR};
    send_topic(ACT_SUB, t, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    t = {8'h61, 8'h62, STAR_CHAR};
    send_topic(ACT_SUB, t, 32'h0000_0011, 32'd5, 0);
    t = {8'h61, 8'h62};
    send_topic(ACT_SUB, t, 32'hFFFF_FFFF, 32'd5, 0);
    send_topic(ACT_PUB, t, 0, 0, 6'd48);
    send_topic(ACT_PUB, t, 0, 0, 6'd0);
    send_topic(ACT_PUB, t, 0, 0, 6'd1);
    // zero byte in the middle ends the text
    t = {8'h61, 8'h00, 8'hFF, 8'h62};
    send_topic(ACT_PUB, t, 0, 0, 6'd48);
    // long topics, stored truncated
    t = {};
    for (int k = 0; k < 48; k++) t.push_back(8'h61);
    send_topic(ACT_SUB, t, 32'h0000_0022, 32'd1, 0);
    t.push_back(STAR_CHAR);
    send_topic(ACT_SUB, t, 32'h0000_0033, 32'd2, 0);
    t.pop_back();
    send_topic(ACT_PUB, t, 0, 0, 6'd48);
    // mixed actions in one topic, the last one decides
    send_item(ACT_SUB, 8'h61, 1'b0, 0, 0, 0);
    send_item(ACT_PUB, 8'h62, 1'b1, 0, 0, 6'd48);
    send_item(ACT_NONE, 8'hFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
    // unsubscribe discards a partial topic
    send_item(ACT_PUB, 8'h61, 1'b0, 0, 0, 0);
    send_item(ACT_UNSUB, 8'h00, 1'b0, 32'hFFFF_FFFF, 0, 0);
    send_item(ACT_UNSUB, 8'h00, 1'b1, 32'h1234_5678, 0, 0);
  endtask

  task automatic run_random(input int items, input logic fill);
    logic [7:0] t[$];
    int sel;
    for (int i = 0; i < items; i++) begin
      sel = $urandom_range(99);
      make_topic(t);
      if (fill && i == 6) begin
        // fill the table past full with one byte topics
        for (int k = 0; k < MAX_SUBS + 1; k++) begin
          t = {((k % 3) == 0) ? STAR_CHAR : 8'h61};
          send_topic(ACT_SUB, t, pick_id(), pick_rank(), 0);
        end
      end else if (sel < 35) begin
        send_topic(ACT_SUB, t, pick_id(), pick_rank(), pick_limit());
      end else if (sel < 75) begin
        send_topic(ACT_PUB, t, pick_id(), pick_rank(), pick_limit());
      end else if (sel < 87) begin
        send_item(ACT_UNSUB, 8'($urandom()), 1'($urandom()), pick_id(), $urandom(),
                  pick_limit());
      end else if (sel < 91) begin
        send_item(ACT_NONE, 8'($urandom()), 1'($urandom()), $urandom(), $urandom(),
                  6'($urandom()));
      end else begin
        // broken sequence: mixed actions and stray zero bytes
        t.push_back($urandom_range(1) ? 8'h00 : 8'h61);
        foreach (t[k])
          send_item(act_e'($urandom_range(1)), t[k], k == t.size() - 1, pick_id(),
                    pick_rank(), pick_limit());
      end
    end
  endtask

  initial begin
    id_pool = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5A5A_A5A5};
    send_idle_pct   = 38;
    recv_idle_pct   = 55;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    action_i        <= ACT_NONE;
    topic_char_i    <= '0;
    topic_last_i    <= 1'b0;
    subscriber_id_i <= '0;
    priority_req_i  <= '0;
    result_limit_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(13, 1'b1);
    send_idle_pct = 55;
    recv_idle_pct = 38;
    run_random(13, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(14, 1'b0);
    in_valid_i <= 1'b0;

    // drain outstanding results, then let the block settle
    while (outstanding != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_topic_subscription_matcher OK");
    end else begin
      $display("tb_topic_subscription_matcher NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40000000;
    $display("tb_topic_subscription_matcher NOT OK");
    $finish;
  end

endmodule
